// ===== rtl/core/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg
// shared types and constants of the rolling standard deviation block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

  localparam int unsigned REG_W      = 9;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned VAR_W      = 64;
  localparam int unsigned SQRT_STEPS = VAR_W / 2;

  localparam logic [PADDR_W-1:0] ADDR_WINDOW_LENGTH = 3'd0;
  localparam logic [REG_W-1:0]   WINDOW_LENGTH_RST  = 9'd20;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUM  = 7'b0000010,
    ST_MEAN = 7'b0000100,
    ST_SQ   = 7'b0001000,
    ST_VAR  = 7'b0010000,
    ST_SQRT = 7'b0100000,
    ST_OUT  = 7'b1000000
  } rsd_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/rsd_in_if.sv =====
// ----------------------------------------------------------------------------
// rsd_in_if
// sample channel: valid/ready handshake with sample and series start
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rsd_in_if #(
  parameter int unsigned SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          series_start;

  modport source (output valid, output sample, output series_start, input ready);
  modport sink   (input valid, input sample, input series_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rsd_out_if.sv =====
// ----------------------------------------------------------------------------
// rsd_out_if
// result channel: valid/ready handshake carrying the standard deviation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rsd_out_if ();
  logic        valid;
  logic        ready;
  logic [31:0] std_dev;

  modport source (output valid, output std_dev, input ready);
  modport sink   (input valid, input std_dev, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rsd_ram.sv =====
// ----------------------------------------------------------------------------
// rsd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rsd_div.sv =====
// ----------------------------------------------------------------------------
// rsd_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsd_div #(
  parameter int unsigned NW = 74,
  parameter int unsigned DW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic      [NW-1:0] quotient_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   dvs_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            fits;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NW-2:0], fits};
      rem_d = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNTW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/rolling_std_deviation.sv =====
// ----------------------------------------------------------------------------
// rolling_std_deviation
// sample standard deviation over a sliding window of the last W samples
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_i     in   valid/ready      sample, series_start
//  out_o    out  valid/ready      std_dev
//  apb      in   psel/penable     window_length at byte address 0
//
//  an item with a result keeps in_i.ready low for two window walks over the
//  ram port, two divider runs, 32 root steps and the output state; out_o.valid
//  rises at the end. an item with no result leaves the block in idle.
//  in_i.ready is high only in idle; a waiting result holds in the output
//  register while the next item is taken, and the block stalls before
//  loading a new result until out_o has taken the old one.
//  reset clears fill count and write position; the ram needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rolling_std_deviation
  import rsd_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  rsd_in_if.sink                  in_i,
  rsd_out_if.source               out_o
);

  localparam int unsigned AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned RW    = (CW > REG_W) ? CW : REG_W;
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SUMW  = SB + AW + 1;
  localparam int unsigned MAGW  = SB + 1;
  localparam int unsigned PRODW = 2 * MAGW;
  localparam int unsigned ACCW  = PRODW + AW;
  localparam int unsigned NW    = ACCW;
  localparam int unsigned QW    = (NW > VAR_W) ? NW : VAR_W + 1;
  localparam int unsigned SCW   = $clog2(SQRT_STEPS);

  rsd_state_e state_q, state_d;

  logic [REG_W-1:0]       win_len_q;
  logic [AW-1:0]          wr_pos_q, wr_pos_next;
  logic [CW-1:0]          fill_q, fill_next;
  logic [CW-1:0]          w_eff;
  logic [AW-1:0]          rd_pos_q, rd_pos_dec;
  logic [CW-1:0]          issue_q;
  logic                   issuing;
  logic                   rd_vld_q;
  logic [SB-1:0]          rdata;
  logic signed [SUMW-1:0] sum_q;
  logic [SUMW-1:0]        sum_mag;
  logic signed [SB:0]     mean_q;
  logic signed [SB+1:0]   diff;
  logic [MAGW-1:0]        mag_q;
  logic                   mag_vld_q;
  logic [PRODW-1:0]       prod_q;
  logic                   prod_vld_q;
  logic [ACCW-1:0]        acc_q;
  logic [VAR_W-1:0]       var_q;
  logic [34:0]            rem_q;
  logic [34:0]            rem_sh, trial;
  logic [OUT_W-1:0]       root_q;
  logic [SCW-1:0]         sq_cnt_q;
  logic [OUT_W-1:0]       std_dev_q;
  logic                   out_vld_q;
  logic                   accept, cfg_wr, go, walk_done;
  logic                   div_start, div_done;
  logic [NW-1:0]          div_dividend, div_quo;
  logic [CW-1:0]          div_divisor;
  logic [QW-1:0]          quo_ext;
  logic [SB:0]            mean_mag;
  logic                   load_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW_LENGTH);
  assign prdata = (paddr == ADDR_WINDOW_LENGTH) ? PDATA_W'(win_len_q) : '0;

  assign w_eff = (RW'(win_len_q) > RW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(win_len_q);

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign wr_pos_next = (wr_pos_q == AW'(MAX_WINDOW - 1)) ? '0 : wr_pos_q + 1'b1;
  always_comb begin
    if (in_i.series_start) begin
      fill_next = CW'(1);
    end else if (fill_q < CW'(MAX_WINDOW)) begin
      fill_next = fill_q + 1'b1;
    end else begin
      fill_next = fill_q;
    end
  end
  assign go = (w_eff >= CW'(2)) && (fill_next >= w_eff);

  assign rd_pos_dec = (rd_pos_q == '0) ? AW'(MAX_WINDOW - 1) : rd_pos_q - 1'b1;
  assign issuing    = ((state_q == ST_SUM) || (state_q == ST_SQ)) && (issue_q < w_eff);
  assign walk_done  = (issue_q == w_eff) && !rd_vld_q && !mag_vld_q && !prod_vld_q;

  rsd_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wr_pos_q),
    .wdata_i (in_i.sample),
    .re_i    (issuing),
    .raddr_i (rd_pos_dec),
    .rdata_o (rdata)
  );

  assign sum_mag = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
  assign diff    = (SB+2)'(signed'(rdata)) - (SB+2)'(mean_q);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = NW'(sum_mag);
    div_divisor  = w_eff;
    if (state_q == ST_SUM && walk_done) begin
      div_start = 1'b1;
    end else if (state_q == ST_SQ && walk_done) begin
      div_start    = 1'b1;
      div_dividend = acc_q;
      div_divisor  = w_eff - 1'b1;
    end
  end

  rsd_div #(
    .NW (NW),
    .DW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign quo_ext  = QW'(div_quo);
  assign mean_mag = div_quo[SB:0];

  assign rem_sh = {rem_q[32:0], var_q[VAR_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  assign load_out = (state_q == ST_OUT) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && go) state_d = ST_SUM;
      ST_SUM:  if (walk_done) state_d = ST_MEAN;
      ST_MEAN: if (div_done) state_d = ST_SQ;
      ST_SQ:   if (walk_done) state_d = ST_VAR;
      ST_VAR:  if (div_done) state_d = ST_SQRT;
      ST_SQRT: if (sq_cnt_q == SCW'(SQRT_STEPS - 1)) state_d = ST_OUT;
      ST_OUT:  if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      win_len_q  <= WINDOW_LENGTH_RST;
      wr_pos_q   <= '0;
      fill_q     <= '0;
      issue_q    <= '0;
      rd_vld_q   <= 1'b0;
      mag_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      sq_cnt_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issuing;
      mag_vld_q  <= (state_q == ST_SQ) && rd_vld_q;
      prod_vld_q <= mag_vld_q;
      if (cfg_wr) begin
        win_len_q <= pwdata[REG_W-1:0];
      end
      if (accept) begin
        wr_pos_q <= wr_pos_next;
        fill_q   <= fill_next;
        issue_q  <= '0;
      end else if (state_q == ST_MEAN && div_done) begin
        issue_q <= '0;
      end else if (issuing) begin
        issue_q <= issue_q + 1'b1;
      end
      if (state_q == ST_VAR) begin
        sq_cnt_q <= '0;
      end else if (state_q == ST_SQRT) begin
        sq_cnt_q <= sq_cnt_q + 1'b1;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_pos_q <= wr_pos_next;
      sum_q    <= '0;
    end else if (state_q == ST_MEAN && div_done) begin
      rd_pos_q <= wr_pos_q;
    end else if (issuing) begin
      rd_pos_q <= rd_pos_dec;
    end
    if (state_q == ST_SUM && rd_vld_q) begin
      sum_q <= sum_q + SUMW'(signed'(rdata));
    end
    if (state_q == ST_MEAN && div_done) begin
      mean_q <= sum_q[SUMW-1] ? -signed'(mean_mag) : signed'(mean_mag);
      acc_q  <= '0;
    end
    mag_q  <= diff[SB+1] ? MAGW'(-diff) : MAGW'(diff);
    prod_q <= mag_q * mag_q;
    if (state_q == ST_SQ && prod_vld_q) begin
      acc_q <= acc_q + ACCW'(prod_q);
    end
    if (state_q == ST_VAR && div_done) begin
      var_q  <= (|quo_ext[QW-1:VAR_W]) ? '1 : quo_ext[VAR_W-1:0];
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == ST_SQRT) begin
      var_q <= {var_q[VAR_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[OUT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[OUT_W-2:0], 1'b0};
      end
    end
    if (load_out) begin
      std_dev_q <= root_q;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.std_dev = std_dev_q;

endmodule

`default_nettype wire

// ===== tb/tb_rolling_std_deviation.sv =====
// ----------------------------------------------------------------------------
// tb_rolling_std_deviation
// self-checking bench for the rolling sample standard deviation block
// ----------------------------------------------------------------------------
//  samples go in from a queue of pending beats, with random gaps. Each
//  accepted beat runs through a bench-side window model, which queues the
//  expected deviation. Every result beat is compared with the oldest
//  expected value. The window length is changed between phases, only while
//  the block is idle. Phases cover the shortest and longest windows, the
//  lengths that give no result, a length past the store size, series
//  restarts, and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_rolling_std_deviation;
  import rsd_pkg::*;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned LIMIT     = 3_000_000;
  localparam int unsigned HOLD_LEN  = 4000;
  localparam int unsigned SETTLE    = 1000;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               series_start;
  } sample_beat_t;

  logic clk_i;
  logic rst_ni;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  rsd_in_if #(.SAMPLE_BITS(32)) in_if ();
  rsd_out_if                    out_if ();

  rolling_std_deviation #(
    .MAX_WINDOW (DEPTH),
    .SAMPLE_BITS(32)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  sample_beat_t       pending_beats[$];
  logic [31:0]        expected_dev[$];
  sample_beat_t       cur_beat;

  logic signed [31:0] win_store[DEPTH];
  int unsigned        win_wpos;
  int unsigned        win_fill;
  int unsigned        win_len;

  int unsigned        cycle_cnt;
  int unsigned        mismatches;
  int unsigned        beats_in;
  int unsigned        beats_out;
  int unsigned        tx_gap;
  int unsigned        rx_gap;
  int unsigned        hold_left;
  logic               hold_req;
  logic               quiet;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // store the sample and queue the deviation it yields, if any
  function automatic void push_sample(sample_beat_t b);
    int unsigned   w;
    int unsigned   p;
    longint        sum;
    longint        mean;
    longint        d;
    logic [63:0]   mag;
    logic [127:0]  acc;
    logic [127:0]  quo;
    logic [63:0]   var_q;
    logic [63:0]   root;
    if (b.series_start) win_fill = 0;
    win_store[win_wpos] = b.sample;
    win_wpos = (win_wpos + 1 >= DEPTH) ? 0 : win_wpos + 1;
    if (win_fill < DEPTH) win_fill++;
    w = (win_len > DEPTH) ? DEPTH : win_len;
    if (w < 2 || win_fill < w) return;
    sum = 0;
    p = win_wpos;
    for (int k = 0; k < w; k++) begin
      p = (p == 0) ? DEPTH - 1 : p - 1;
      sum += longint'(win_store[p]);
    end
    mean = sum / longint'(w);
    acc = '0;
    p = win_wpos;
    for (int k = 0; k < w; k++) begin
      p = (p == 0) ? DEPTH - 1 : p - 1;
      d = longint'(win_store[p]) - mean;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      acc += {64'd0, mag} * {64'd0, mag};
    end
    quo = acc / 128'(w - 1);
    var_q = (quo[127:64] != 0) ? '1 : quo[63:0];
    root = isqrt64(var_q);
    expected_dev = {expected_dev, root[31:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.sample       <= '0;
      in_if.series_start <= 1'b0;
      tx_gap             <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        push_sample(cur_beat);
        beats_in <= beats_in + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap      <= tx_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            tx_gap      <= $urandom_range(0, 4);
            in_if.valid <= 1'b0;
          end else begin
            cur_beat            = pending_beats.pop_front();
            in_if.valid        <= 1'b1;
            in_if.sample       <= cur_beat.sample;
            in_if.series_start <= cur_beat.series_start;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] exp_v;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_gap       <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        beats_out <= beats_out + 1;
        if (expected_dev.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("error: unexpected result beat std_dev=%h", out_if.std_dev);
        end else begin
          exp_v = expected_dev.pop_front();
          if (exp_v !== out_if.std_dev) begin
            mismatches++;
            if (mismatches <= 10)
              $display("error: std_dev expected %h actual %h", exp_v, out_if.std_dev);
          end
        end
      end
      if (hold_left > 1 || (hold_req && hold_left == 0)) begin
        out_if.ready <= 1'b0;
      end else if (quiet) begin
        out_if.ready <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap       <= rx_gap - 1;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        rx_gap       <= $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    win_len = data & 32'h1FF;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_beats.size() > 0 || in_if.valid || expected_dev.size() > 0);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic void add_beat(logic signed [31:0] s, logic st);
    sample_beat_t b;
    b.sample       = s;
    b.series_start = st;
    pending_beats = {pending_beats, b};
  endfunction

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 65535)) - 32768;
      2:       return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF - $urandom_range(0, 255)
                                                  : 32'sh8000_0000 + $urandom_range(0, 255);
      default: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    endcase
  endfunction

  task automatic random_phase(input int unsigned len, input int unsigned n);
    reg_write(ADDR_WINDOW_LENGTH, len);
    add_beat(rand_sample(), 1'b1);
    for (int i = 1; i < n; i++) add_beat(rand_sample(), $urandom_range(0, 40) == 0);
  endtask

  initial begin
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    hold_req   = 1'b0;
    quiet      = 1'b0;
    cycle_cnt  = 0;
    mismatches = 0;
    beats_in   = 0;
    beats_out  = 0;
    win_wpos   = 0;
    win_fill   = 0;
    win_len    = WINDOW_LENGTH_RST;
    rst_ni     = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window length of 20, then shortest window with extremes
    for (int i = 0; i < 21; i++) add_beat(i * 1000, 1'b0);
    drain();
    reg_write(ADDR_WINDOW_LENGTH, 2);
    add_beat(32'sh7FFF_FFFF, 1'b1);
    add_beat(32'sh8000_0000, 1'b0);
    add_beat(32'sh7FFF_FFFF, 1'b0);
    add_beat(0, 1'b0);
    add_beat(-1, 1'b0);
    add_beat(32'sh5555_5555, 1'b1);
    add_beat(32'shAAAA_AAAA, 1'b0);
    drain();
    reg_write(ADDR_WINDOW_LENGTH, 0);
    add_beat(123, 1'b0);
    add_beat(-456, 1'b0);
    drain();
    reg_write(ADDR_WINDOW_LENGTH, 1);
    add_beat(789, 1'b1);
    add_beat(-1, 1'b0);
    drain();

    // past the store size, and the full store
    random_phase(511, 258);
    drain();
    random_phase(256, 2);
    drain();

    random_phase(3, 40);
    drain();
    random_phase($urandom_range(4, 40), 70);
    hold_req = 1'b1;
    drain();
    hold_req = 1'b0;
    random_phase($urandom_range(2, 40), 70);
    drain();
    quiet = 1'b1;
    random_phase($urandom_range(2, 40), 60);
    drain();
    repeat (SETTLE) @(posedge clk_i);

    if (expected_dev.size() != 0) mismatches++;
    $display("run covered %0d samples and %0d results over window lengths 0..511",
             beats_in, beats_out);
    $display("with series restarts, a long result hold-off and %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
